/* hw/rtl/sit_pkg.sv */
// Shared types and constants for the segment intersection test core.
`default_nettype none

package sit_pkg;

    localparam int CoordWidthDefault = 16;
    localparam int CoordWidthMin     = 8;
    localparam int CoordWidthMax     = 31;

    // Sign of an orientation cross product.
    typedef enum logic [1:0] {
        ORIENT_ZERO = 2'b00,
        ORIENT_POS  = 2'b01,
        ORIENT_NEG  = 2'b10
    } orient_t;

endpackage

`default_nettype wire

/* hw/rtl/sit_orient.sv */
// Two-stage orientation unit: sign of (q - p) x (r - p).
`default_nettype none

module sit_orient #(
    parameter int COORD_WIDTH = sit_pkg::CoordWidthDefault
) (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic signed [COORD_WIDTH-1:0] px,
    input  wire logic signed [COORD_WIDTH-1:0] py,
    input  wire logic signed [COORD_WIDTH-1:0] qx,
    input  wire logic signed [COORD_WIDTH-1:0] qy,
    input  wire logic signed [COORD_WIDTH-1:0] rx,
    input  wire logic signed [COORD_WIDTH-1:0] ry,
    output sit_pkg::orient_t                   orient
);
    import sit_pkg::*;

    localparam int DiffWidth = COORD_WIDTH + 1;
    localparam int ProdWidth = 2 * DiffWidth;

    logic signed [DiffWidth-1:0] dqx_reg, dqy_reg, drx_reg, dry_reg;
    logic signed [DiffWidth-1:0] dqx_next, dqy_next, drx_next, dry_next;
    logic signed [ProdWidth-1:0] lhs_reg, rhs_reg;
    logic signed [ProdWidth-1:0] lhs_next, rhs_next;

    always_comb begin
        dqx_next = DiffWidth'(qx) - DiffWidth'(px);
        dqy_next = DiffWidth'(qy) - DiffWidth'(py);
        drx_next = DiffWidth'(rx) - DiffWidth'(px);
        dry_next = DiffWidth'(ry) - DiffWidth'(py);
        lhs_next = ProdWidth'(dqx_reg) * ProdWidth'(dry_reg);
        rhs_next = ProdWidth'(dqy_reg) * ProdWidth'(drx_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dqx_reg <= dqx_next;
            dqy_reg <= dqy_next;
            drx_reg <= drx_next;
            dry_reg <= dry_next;
            lhs_reg <= lhs_next;
            rhs_reg <= rhs_next;
        end
    end

    always_comb begin
        priority if (lhs_reg > rhs_reg) begin
            orient = ORIENT_POS;
        end else if (lhs_reg < rhs_reg) begin
            orient = ORIENT_NEG;
        end else begin
            orient = ORIENT_ZERO;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/segment_intersection_test_core.sv */
// Top level: streaming test of whether two closed integer segments share a point.
// Pipeline: input register, difference stage, product stage, result register,
//   all held while the output stalls.
// Throughput without stall: one request per cycle; four cross products in parallel.
// An input skid register keeps s_tready registered; it drops for one stalled request.
// Reset (aresetn low, synchronous) empties the pipeline and the skid register.
`default_nettype none

module segment_intersection_test_core #(
    parameter int COORD_WIDTH = sit_pkg::CoordWidthDefault
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // ax0, ay0, ax1, ay1, bx0, by0, bx1, by1 (COORD_WIDTH each, low bits first)
    input  wire logic [8*COORD_WIDTH-1:0] s_tdata,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // crosses in bit 0, zeros above
    output logic [7:0]                    m_tdata
);
    import sit_pkg::*;

    localparam int InWidth = 8 * COORD_WIDTH;

    // Coordinate slots within the request
    localparam int IdxAx0 = 0;
    localparam int IdxAy0 = 1;
    localparam int IdxAx1 = 2;
    localparam int IdxAy1 = 3;
    localparam int IdxBx0 = 4;
    localparam int IdxBy0 = 5;
    localparam int IdxBx1 = 6;
    localparam int IdxBy1 = 7;

    function automatic logic between(input logic signed [COORD_WIDTH-1:0] p,
                                     input logic signed [COORD_WIDTH-1:0] q,
                                     input logic signed [COORD_WIDTH-1:0] r);
        between = (r >= p || r >= q) && (r <= p || r <= q);
    endfunction

    logic               adv;
    logic               s_accept;

    logic               skid_valid_reg, skid_valid_next;
    logic [InWidth-1:0] skid_data_reg;
    logic               in_valid_reg, in_valid_next;
    logic [InWidth-1:0] in_data_reg, in_data_next;
    logic               d_valid_reg;
    logic               p_valid_reg;
    logic               out_valid_reg;
    logic [7:0]         out_data_reg, out_data_next;

    logic [3:0]         box_next, box_d_reg, box_p_reg;

    logic signed [COORD_WIDTH-1:0] crd [8];
    orient_t                       o1, o2, o3, o4;
    logic                          proper, touch;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        skid_valid_next = skid_valid_reg;
        in_valid_next   = in_valid_reg;
        in_data_next    = in_data_reg;
        if (adv) begin
            skid_valid_next = 1'b0;
            in_valid_next   = skid_valid_reg || s_accept;
            in_data_next    = skid_valid_reg ? skid_data_reg : s_tdata;
        end else if (s_accept) begin
            skid_valid_next = 1'b1;
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            crd[i] = in_data_reg[i*COORD_WIDTH +: COORD_WIDTH];
        end
        box_next[0] = between(crd[IdxAx0], crd[IdxAx1], crd[IdxBx0])
                   && between(crd[IdxAy0], crd[IdxAy1], crd[IdxBy0]);
        box_next[1] = between(crd[IdxAx0], crd[IdxAx1], crd[IdxBx1])
                   && between(crd[IdxAy0], crd[IdxAy1], crd[IdxBy1]);
        box_next[2] = between(crd[IdxBx0], crd[IdxBx1], crd[IdxAx0])
                   && between(crd[IdxBy0], crd[IdxBy1], crd[IdxAy0]);
        box_next[3] = between(crd[IdxBx0], crd[IdxBx1], crd[IdxAx1])
                   && between(crd[IdxBy0], crd[IdxBy1], crd[IdxAy1]);
    end

    sit_orient #(.COORD_WIDTH(COORD_WIDTH)) u_orient1 (
        .aclk(aclk), .en(adv),
        .px(crd[IdxAx0]), .py(crd[IdxAy0]), .qx(crd[IdxAx1]), .qy(crd[IdxAy1]),
        .rx(crd[IdxBx0]), .ry(crd[IdxBy0]), .orient(o1)
    );
    sit_orient #(.COORD_WIDTH(COORD_WIDTH)) u_orient2 (
        .aclk(aclk), .en(adv),
        .px(crd[IdxAx0]), .py(crd[IdxAy0]), .qx(crd[IdxAx1]), .qy(crd[IdxAy1]),
        .rx(crd[IdxBx1]), .ry(crd[IdxBy1]), .orient(o2)
    );
    sit_orient #(.COORD_WIDTH(COORD_WIDTH)) u_orient3 (
        .aclk(aclk), .en(adv),
        .px(crd[IdxBx0]), .py(crd[IdxBy0]), .qx(crd[IdxBx1]), .qy(crd[IdxBy1]),
        .rx(crd[IdxAx0]), .ry(crd[IdxAy0]), .orient(o3)
    );
    sit_orient #(.COORD_WIDTH(COORD_WIDTH)) u_orient4 (
        .aclk(aclk), .en(adv),
        .px(crd[IdxBx0]), .py(crd[IdxBy0]), .qx(crd[IdxBx1]), .qy(crd[IdxBy1]),
        .rx(crd[IdxAx1]), .ry(crd[IdxAy1]), .orient(o4)
    );

    always_comb begin
        proper = (o1 != ORIENT_ZERO) && (o2 != ORIENT_ZERO)
              && (o3 != ORIENT_ZERO) && (o4 != ORIENT_ZERO)
              && (o1 != o2) && (o3 != o4);
        touch  = ((o1 == ORIENT_ZERO) && box_p_reg[0])
              || ((o2 == ORIENT_ZERO) && box_p_reg[1])
              || ((o3 == ORIENT_ZERO) && box_p_reg[2])
              || ((o4 == ORIENT_ZERO) && box_p_reg[3]);
        out_data_next = {7'b0, proper || touch};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
            in_valid_reg   <= 1'b0;
            d_valid_reg    <= 1'b0;
            p_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            skid_valid_reg <= skid_valid_next;
            in_valid_reg   <= in_valid_next;
            if (adv) begin
                d_valid_reg   <= in_valid_reg;
                p_valid_reg   <= d_valid_reg;
                out_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!adv && s_accept) begin
            skid_data_reg <= s_tdata;
        end
        in_data_reg <= in_data_next;
        if (adv) begin
            box_d_reg    <= box_next;
            box_p_reg    <= box_d_reg;
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/sit_checker.sv */
// Port-level checker for the segment intersection test core, bound to the top level.
`default_nettype none

module sit_checker #(
    parameter int COORD_WIDTH = sit_pkg::CoordWidthDefault
) (
    input wire logic                     aclk,
    input wire logic                     aresetn,
    input wire logic                     s_tvalid,
    input wire logic                     s_tready,
    input wire logic [8*COORD_WIDTH-1:0] s_tdata,
    input wire logic                     m_tvalid,
    input wire logic                     m_tready,
    input wire logic [7:0]               m_tdata
);
    import sit_pkg::*;

    // Pipeline is empty and open right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("core not empty after reset");

    // Input only backs up behind a held result
    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("s_tready low with no result pending");

    // Result padding bits stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:1] == 7'b0)
        else $error("nonzero padding in result");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

    // Stalled request on input would be a sender issue; a taken request with
    // nothing pending output-side cannot back up the next cycle
    a_no_backup: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> s_tready)
        else $error("input backed up with output empty");

endmodule

bind segment_intersection_test_core sit_checker #(.COORD_WIDTH(COORD_WIDTH)) u_sit_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
);

`default_nettype wire

/* sim/testbench.sv */
// Testbench for segment_intersection_test_core: directed table plus random segment pairs.
`default_nettype none

module testbench;
    import sit_pkg::*;

    localparam int CoordW      = CoordWidthDefault;
    localparam int RandomPairs = 700;
    localparam int HoldCycles  = 60;
    localparam int DrainCycles = 12;
    localparam int CycleLimit  = 200000;
    localparam int DirRows     = 23;

    typedef logic signed [CoordW-1:0] coord_t;

    // ax0 in the low bits, so the struct maps straight onto s_tdata
    typedef struct packed {
        coord_t by1, bx1, by0, bx0, ay1, ax1, ay0, ax0;
    } seg_pair_t;

    typedef enum int {
        ANS_MISS,
        ANS_HIT,
        ANS_PREDICT
    } answer_t;

    // ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, answer
    localparam int DirTable [DirRows][9] = '{
        '{0, 0, 10, 10, 0, 10, 10, 0, ANS_HIT},                        // proper crossing
        '{10, 10, 0, 0, 10, 0, 0, 10, ANS_HIT},                        // reversed endpoints
        '{0, 0, 10, 0, 0, 1, 10, 1, ANS_MISS},                         // parallel apart
        '{0, 0, 5, 5, 5, 5, 9, 0, ANS_HIT},                            // shared endpoint
        '{0, 0, 10, 0, 5, 0, 5, 7, ANS_HIT},                           // T junction
        '{0, 0, 10, 0, 5, 0, 15, 0, ANS_HIT},                          // collinear overlap
        '{0, 0, 4, 4, 6, 6, 9, 9, ANS_MISS},                           // collinear, gap
        '{0, 0, 4, 4, 4, 4, 9, 9, ANS_HIT},                            // collinear, touch
        '{-10, -10, 10, 10, -1, -1, 1, 1, ANS_HIT},                    // collinear, nested
        '{5, -3, 5, 3, 5, 2, 5, 9, ANS_HIT},                           // vertical overlap
        '{5, -3, 5, 1, 5, 2, 5, 9, ANS_MISS},                          // vertical gap
        '{3, 3, 3, 3, 0, 0, 6, 6, ANS_HIT},                            // point on segment
        '{3, 4, 3, 4, 0, 0, 6, 6, ANS_MISS},                           // point off line
        '{7, 7, 7, 7, 0, 0, 6, 6, ANS_MISS},                           // point past the end
        '{2, -2, 2, -2, 2, -2, 2, -2, ANS_HIT},                        // equal points
        '{2, -2, 2, -2, -2, 2, -2, 2, ANS_MISS},                       // distinct points
        '{0, 0, 10, 0, 5, 1, 6, 9, ANS_MISS},                          // near miss
        '{0, 0, 10, 0, 11, 0, 12, 5, ANS_PREDICT},                     // on the extension
        '{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768, ANS_HIT},
        '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, ANS_HIT},
        '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, ANS_HIT},
        '{-32768, -32768, 32767, 32766, 32767, 32767, 32767, 32767, ANS_PREDICT},
        '{32767, -32768, 32767, 32767, -32768, 0, 32767, 0, ANS_HIT}
    };

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [8*CoordW-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;

    answer_t  answer_plan[$];
    bit       crossing_due[$];
    int       failures;
    int       sent_count;
    int       taken_count;
    int       cycle_count;
    bit       idle_on;
    bit       stall_request;

    segment_intersection_test_core #(
        .COORD_WIDTH(CoordW)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic orient_t turn_of(longint px, longint py, longint qx, longint qy,
                                        longint rx, longint ry);
        longint lhs;
        longint rhs;
        lhs = (qx - px) * (ry - py);
        rhs = (qy - py) * (rx - px);
        if (lhs > rhs) return ORIENT_POS;
        if (lhs < rhs) return ORIENT_NEG;
        return ORIENT_ZERO;
    endfunction

    function automatic bit within_box(longint px, longint py, longint qx, longint qy,
                                      longint rx, longint ry);
        return rx >= (px < qx ? px : qx) && rx <= (px < qx ? qx : px) &&
               ry >= (py < qy ? py : qy) && ry <= (py < qy ? qy : py);
    endfunction

    function automatic bit crossing_of(seg_pair_t p);
        longint  ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
        orient_t o1, o2, o3, o4;
        ax0 = $signed(p.ax0);
        ay0 = $signed(p.ay0);
        ax1 = $signed(p.ax1);
        ay1 = $signed(p.ay1);
        bx0 = $signed(p.bx0);
        by0 = $signed(p.by0);
        bx1 = $signed(p.bx1);
        by1 = $signed(p.by1);
        o1 = turn_of(ax0, ay0, ax1, ay1, bx0, by0);
        o2 = turn_of(ax0, ay0, ax1, ay1, bx1, by1);
        o3 = turn_of(bx0, by0, bx1, by1, ax0, ay0);
        o4 = turn_of(bx0, by0, bx1, by1, ax1, ay1);
        if (o1 != ORIENT_ZERO && o2 != ORIENT_ZERO && o3 != ORIENT_ZERO &&
            o4 != ORIENT_ZERO && o1 != o2 && o3 != o4)
            return 1'b1;
        if (o1 == ORIENT_ZERO && within_box(ax0, ay0, ax1, ay1, bx0, by0)) return 1'b1;
        if (o2 == ORIENT_ZERO && within_box(ax0, ay0, ax1, ay1, bx1, by1)) return 1'b1;
        if (o3 == ORIENT_ZERO && within_box(bx0, by0, bx1, by1, ax0, ay0)) return 1'b1;
        if (o4 == ORIENT_ZERO && within_box(bx0, by0, bx1, by1, ax1, ay1)) return 1'b1;
        return 1'b0;
    endfunction

    function automatic seg_pair_t pair_of(int c[8]);
        seg_pair_t p;
        for (int i = 0; i < 8; i++) begin
            p[i*CoordW +: CoordW] = c[i][CoordW-1:0];
        end
        return p;
    endfunction

    function automatic int extreme_coord();
        case ($urandom_range(0, 6))
            0: return -32768;
            1: return -32767;
            2: return -1;
            3: return 0;
            4: return 1;
            5: return 32766;
            default: return 32767;
        endcase
    endfunction

    // entered and left on a falling edge
    task automatic send_pair(seg_pair_t p, answer_t a);
        answer_plan.push_back(a);
        sent_count++;
        while (idle_on && $urandom_range(0, 99) < 29) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // receiver
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_request) begin
                stall_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HoldCycles) @(negedge aclk);
            end else begin
                m_tready <= !idle_on || $urandom_range(0, 99) >= 29;
            end
        end
    end

    // request capture and result check
    always @(posedge aclk) begin
        answer_t a;
        bit      want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                if (answer_plan.size() == 0) begin
                    $error("request taken with nothing planned");
                    failures++;
                end else begin
                    a = answer_plan.pop_front();
                    taken_count++;
                    if (a == ANS_PREDICT)
                        crossing_due.push_back(crossing_of(seg_pair_t'(s_tdata)));
                    else
                        crossing_due.push_back(a == ANS_HIT);
                end
            end
            if (m_tvalid && m_tready) begin
                if (crossing_due.size() == 0) begin
                    $error("result with no request outstanding: m_tdata=%h", m_tdata);
                    failures++;
                end else begin
                    want = crossing_due.pop_front();
                    if (m_tdata[0] !== want) begin
                        $error("crosses: expected %0d, actual %0d", want, m_tdata[0]);
                        failures++;
                    end
                    if (m_tdata[7:1] !== 7'd0) begin
                        $error("m_tdata padding: expected 0, actual %h", m_tdata[7:1]);
                        failures++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int        c[8];
        int        bx, by, dx, dy, k, i, j;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        failures      = 0;
        sent_count    = 0;
        taken_count   = 0;
        cycle_count   = 0;
        idle_on       = 1'b1;
        stall_request = 1'b0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int r = 0; r < DirRows; r++) begin
            for (int f = 0; f < 8; f++) c[f] = DirTable[r][f];
            send_pair(pair_of(c), answer_t'(DirTable[r][8]));
        end

        for (int n = 0; n < RandomPairs; n++) begin
            if (n == 150 || n == 480) stall_request = 1'b1;
            idle_on = !(n >= 300 && n < 420);
            case ($urandom_range(0, 9))
                2, 3: begin
                    for (int f = 0; f < 8; f++) c[f] = int'($urandom_range(0, 12)) - 6;
                end
                4: begin
                    // four points on one line
                    bx = int'($urandom_range(0, 2000)) - 1000;
                    by = int'($urandom_range(0, 2000)) - 1000;
                    dx = int'($urandom_range(0, 6)) - 3;
                    dy = int'($urandom_range(0, 6)) - 3;
                    for (int e = 0; e < 4; e++) begin
                        k = int'($urandom_range(0, 40)) - 20;
                        c[2*e]   = bx + k * dx;
                        c[2*e+1] = by + k * dy;
                    end
                end
                5: begin
                    for (int f = 0; f < 8; f++) c[f] = int'($urandom_range(0, 8)) - 4;
                    c[2] = c[0];
                    c[3] = c[1];
                    if ($urandom_range(0, 1)) begin
                        c[6] = c[4];
                        c[7] = c[5];
                    end
                    if ($urandom_range(0, 3) == 0) begin
                        c[4] = c[0];
                        c[5] = c[1];
                    end
                end
                6: begin
                    for (int f = 0; f < 8; f++) c[f] = int'($urandom());
                    i = 2 * $urandom_range(0, 1);
                    j = 4 + 2 * $urandom_range(0, 1);
                    c[j]   = c[i];
                    c[j+1] = c[i+1];
                end
                7: begin
                    for (int f = 0; f < 8; f++) c[f] = extreme_coord();
                end
                8: begin
                    // B starts or ends on the midpoint of A
                    bx = int'($urandom_range(0, 60000)) - 30000;
                    by = int'($urandom_range(0, 60000)) - 30000;
                    dx = int'($urandom_range(0, 2000)) - 1000;
                    dy = int'($urandom_range(0, 2000)) - 1000;
                    c[0] = bx - dx;
                    c[1] = by - dy;
                    c[2] = bx + dx;
                    c[3] = by + dy;
                    c[4] = bx;
                    c[5] = by;
                    c[6] = int'($urandom());
                    c[7] = int'($urandom());
                    if ($urandom_range(0, 1)) begin
                        c[4] = c[6];
                        c[5] = c[7];
                        c[6] = bx;
                        c[7] = by;
                    end
                end
                default: begin
                    for (int f = 0; f < 8; f++) c[f] = int'($urandom());
                end
            endcase
            send_pair(pair_of(c), ANS_PREDICT);
        end
        s_tvalid <= 1'b0;
        idle_on = 1'b1;

        while (taken_count != sent_count || crossing_due.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
        if (crossing_due.size() != 0) begin
            $error("%0d results never arrived", crossing_due.size());
            failures++;
        end
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

/* segment_intersection_test_core.f */
hw/rtl/sit_pkg.sv
hw/rtl/sit_orient.sv
hw/rtl/segment_intersection_test_core.sv
hw/rtl/sit_checker.sv
sim/testbench.sv
